// ----- hw/rtl/history_and_fail_high_table_core_defines.svh -----
// ---------------------------------------------------------------------------
// History and fail-high table: assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HISTORY_AND_FAIL_HIGH_TABLE_CORE_DEFINES_SVH
`define HISTORY_AND_FAIL_HIGH_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HAFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HAFH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define HAFH_ASSERT(lbl, prop, msg)
`define HAFH_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/hafh_pkg.sv -----
// ---------------------------------------------------------------------------
// History and fail-high table package
// Sizes, action codes, states and memory port types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package hafh_pkg;
  localparam int PIECE_KINDS   = 14;
  localparam int SQUARES       = 128;
  localparam int STATS_ENTRIES = 131072;
  localparam int HISTORY_BITS  = 24;
  localparam int PLY_UNITS     = 16;

  localparam int PIECE_W = 4;
  localparam int SQ_W    = 7;
  localparam int SIDX_W  = 17;
  localparam int DEPTH_W = 10;
  localparam int HV_W    = 24;
  localparam int PCT_W   = 7;
  localparam int STAT_W  = 16;

  localparam int HIST_ENTRIES = PIECE_KINDS * SQUARES;
  localparam int HIST_AW      = $clog2(HIST_ENTRIES);
  localparam int STATS_AW     = $clog2(STATS_ENTRIES);
  localparam int CLR_ENTRIES  = (HIST_ENTRIES > STATS_ENTRIES) ? HIST_ENTRIES : STATS_ENTRIES;
  localparam int CNT_W        = $clog2(CLR_ENTRIES + 1);

  localparam int PLY_W   = $clog2(((1 << DEPTH_W) - 1) / PLY_UNITS + 2);
  localparam int INC_W   = 2 * PLY_W;
  localparam int SUM_W   = ((HISTORY_BITS > INC_W) ? HISTORY_BITS : INC_W) + 1;
  localparam int SH_STEPS = (SUM_W - HISTORY_BITS + 3) / 4;
  localparam int SHIFT_W = $clog2(SUM_W + 1);

  localparam int PCT_SCALE = 100;
  localparam int NUM_W     = STAT_W + $clog2(PCT_SCALE + 1);
  localparam logic [STAT_W-1:0] STAT_MAX = 16'hFFFF;
  localparam logic [STAT_W-1:0] STAT_ONE = 16'h0001;

  typedef enum logic [2:0] {
    ACT_REWARD   = 3'd0,
    ACT_PENALIZE = 3'd1,
    ACT_QUERY    = 3'd2,
    ACT_AGE      = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_AGE, ST_READ, ST_MOD, ST_SCALE, ST_DSTART, ST_DWAIT
  } state_t;

  typedef struct packed {
    logic                    en;
    logic [HIST_AW-1:0]      addr;
    logic [HISTORY_BITS-1:0] data;
  } hist_wr_t;

  typedef struct packed {
    logic                en;
    logic [STATS_AW-1:0] addr;
    logic [STAT_W-1:0]   fail;
    logic [STAT_W-1:0]   att;
  } stat_wr_t;
endpackage

// ----- hw/rtl/history_and_fail_high_table_core.sv -----
// ---------------------------------------------------------------------------
// History and fail-high table core
// History counters per piece and square plus fail-high statistics pairs.
// ---------------------------------------------------------------------------
// Use: drive in_* with start high; the item transfers at an edge where busy
// is low. Each item gives one result, shown for one cycle with out_valid.
// The receiver cannot stall; results are never held back.
// Reward, penalize and query: the item passes modify and write-back,
// divider load, seven divider steps, divider done and the output register;
// the next item may transfer in the cycle the result appears.
// Reward that overflows the history counter: a rescale sweep through the
// history memory port comes before the divider load.
// Age: a sweep through the history memory and a read state, then the
// steps of a query.
// Clear: a clearing pass over both memories and a read state, then the
// steps of a query.
// Reset: the same clearing pass runs with busy high; no item is taken
// until it ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "history_and_fail_high_table_core_defines.svh"
module history_and_fail_high_table_core import hafh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic [PIECE_W-1:0] in_moved_piece,
  input  logic [SQ_W-1:0]    in_to_square,
  input  logic [SIDX_W-1:0]  in_stats_index,
  input  logic [DEPTH_W-1:0] in_remaining_depth,
  output logic               out_valid,
  output logic [HV_W-1:0]    out_history_value,
  output logic [PCT_W-1:0]   out_fail_high_percent
);
  state_t                  state_r, state_nxt;
  action_t                 act_r;
  logic [PIECE_W-1:0]      piece_r;
  logic [SQ_W-1:0]         sq_r;
  logic [SIDX_W-1:0]       sidx_r;
  logic [DEPTH_W-1:0]      depth_r;
  logic                    item_r, item_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    sw_rv_r;
  logic [HIST_AW-1:0]      sw_waddr_r;
  logic [SHIFT_W-1:0]      sh_r, sh_nxt;
  logic [HISTORY_BITS-1:0] hv_r, hv_nxt;
  logic [STAT_W-1:0]       f_r, f_nxt, a_r, a_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [HV_W-1:0]         out_hv_r;
  logic [PCT_W-1:0]        out_pct_r;
  logic                    load_item, set_query;

  logic [PIECE_W-1:0]      pt_piece;
  logic [SQ_W-1:0]         pt_sq;
  logic [SIDX_W-1:0]       pt_sidx;
  logic [HIST_AW-1:0]      hidx;
  logic                    hist_ok, stat_ok, sweeping;
  logic [HIST_AW-1:0]      hist_rd_addr;
  logic [HISTORY_BITS-1:0] hist_rd;
  logic [STAT_W-1:0]       stat_rd_fail, stat_rd_att;
  hist_wr_t                hist_wr;
  stat_wr_t                stat_wr;

  logic [PLY_W-1:0]        plies, plies1, dec;
  logic [INC_W-1:0]        inc;
  logic [SUM_W-1:0]        sum, sum_sh;
  logic [SHIFT_W-1:0]      sh_calc;
  logic [HISTORY_BITS-1:0] pen_val;
  logic [STAT_W-1:0]       rw_f, rw_a, pn_f, pn_a;

  logic                    div_start, div_done;
  logic [PCT_W-1:0]        div_quot;

  assign pt_piece = (state_r == ST_IDLE) ? in_moved_piece : piece_r;
  assign pt_sq    = (state_r == ST_IDLE) ? in_to_square   : sq_r;
  assign pt_sidx  = (state_r == ST_IDLE) ? in_stats_index : sidx_r;
  assign hist_ok  = (32'(pt_piece) < PIECE_KINDS) && (32'(pt_sq) < SQUARES);
  assign stat_ok  = 32'(pt_sidx) < STATS_ENTRIES;
  assign hidx     = HIST_AW'(pt_piece) * HIST_AW'(SQUARES) + HIST_AW'(pt_sq);
  assign sweeping = (state_r == ST_AGE) || (state_r == ST_SCALE);
  assign hist_rd_addr = sweeping ? cnt_r[HIST_AW-1:0] : hidx;

  assign plies  = PLY_W'(depth_r / PLY_UNITS);
  assign plies1 = plies + 1'b1;
  assign inc    = INC_W'(plies1) * INC_W'(plies1);
  assign dec    = (plies >> 2) + 1'b1;
  assign sum    = SUM_W'(hist_rd) + SUM_W'(inc);
  assign pen_val = (SUM_W'(hist_rd) >= SUM_W'(dec)) ? hist_rd - HISTORY_BITS'(dec) : '0;

  always_comb begin
    sum_sh  = sum;
    sh_calc = '0;
    for (int k = 0; k < SH_STEPS; k++) begin
      if ((sum_sh >> HISTORY_BITS) != '0) begin
        sum_sh  = sum_sh >> 4;
        sh_calc = sh_calc + SHIFT_W'(4);
      end
    end
  end

  always_comb begin
    rw_f = stat_rd_fail;
    rw_a = stat_rd_att;
    if ((rw_f == STAT_MAX) || (rw_a == STAT_MAX)) begin
      rw_f = rw_f >> 1;
      rw_a = rw_a >> 1;
    end
    rw_f = rw_f + 1'b1;
    rw_a = rw_a + 1'b1;
    pn_f = stat_rd_fail;
    pn_a = stat_rd_att;
    if (pn_a == STAT_MAX) begin
      pn_f = pn_f >> 1;
      pn_a = pn_a >> 1;
    end
    pn_a = pn_a + 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    sh_nxt        = sh_r;
    hv_nxt        = hv_r;
    f_nxt         = f_r;
    a_nxt         = a_r;
    out_valid_nxt = 1'b0;
    load_item     = 1'b0;
    set_query     = 1'b0;
    div_start     = 1'b0;
    hist_wr       = '0;
    stat_wr       = '0;
    unique case (state_r)
      ST_CLR: begin
        if (32'(cnt_r) < HIST_ENTRIES) begin
          hist_wr.en   = 1'b1;
          hist_wr.addr = cnt_r[HIST_AW-1:0];
        end
        if (32'(cnt_r) < STATS_ENTRIES) begin
          stat_wr.en   = 1'b1;
          stat_wr.addr = cnt_r[STATS_AW-1:0];
          stat_wr.fail = STAT_ONE;
          stat_wr.att  = STAT_ONE;
        end
        if (32'(cnt_r) == CLR_ENTRIES - 1) begin
          set_query = 1'b1;
          state_nxt = item_r ? ST_READ : ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          load_item = 1'b1;
          item_nxt  = 1'b1;
          cnt_nxt   = '0;
          case (action_t'(in_action))
            ACT_AGE: begin
              sh_nxt    = SHIFT_W'(1);
              state_nxt = ST_AGE;
            end
            ACT_CLEAR: state_nxt = ST_CLR;
            default:   state_nxt = ST_MOD;
          endcase
        end
      end
      ST_AGE, ST_SCALE: begin
        if (32'(cnt_r) < HIST_ENTRIES) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          set_query = 1'b1;
          state_nxt = (state_r == ST_AGE) ? ST_READ : ST_DSTART;
        end
        if (sw_rv_r) begin
          hist_wr.en   = 1'b1;
          hist_wr.addr = sw_waddr_r;
          hist_wr.data = ((state_r == ST_SCALE) && (sw_waddr_r == hidx)) ? hv_r
                         : hist_rd >> sh_r;
        end
      end
      ST_READ: state_nxt = ST_MOD;
      ST_MOD: begin
        state_nxt = ST_DSTART;
        hv_nxt    = hist_ok ? hist_rd : '0;
        f_nxt     = stat_ok ? stat_rd_fail : '0;
        a_nxt     = stat_ok ? stat_rd_att : '0;
        hist_wr.addr = hidx;
        stat_wr.addr = STATS_AW'(pt_sidx);
        case (act_r)
          ACT_REWARD: begin
            if (hist_ok) begin
              hv_nxt = HISTORY_BITS'(sum_sh);
              if (sh_calc != '0) begin
                sh_nxt    = sh_calc;
                cnt_nxt   = '0;
                state_nxt = ST_SCALE;
              end else begin
                hist_wr.en   = 1'b1;
                hist_wr.data = HISTORY_BITS'(sum);
              end
            end
            if (stat_ok) begin
              stat_wr.en   = 1'b1;
              stat_wr.fail = rw_f;
              stat_wr.att  = rw_a;
              f_nxt        = rw_f;
              a_nxt        = rw_a;
            end
          end
          ACT_PENALIZE: begin
            if (hist_ok) begin
              hv_nxt       = pen_val;
              hist_wr.en   = 1'b1;
              hist_wr.data = pen_val;
            end
            if (stat_ok) begin
              stat_wr.en   = 1'b1;
              stat_wr.fail = pn_f;
              stat_wr.att  = pn_a;
              f_nxt        = pn_f;
              a_nxt        = pn_a;
            end
          end
          default: ;
        endcase
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          item_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      item_r      <= 1'b0;
      sw_rv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      item_r      <= item_nxt;
      sw_rv_r     <= sweeping && (32'(cnt_r) < HIST_ENTRIES);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      act_r   <= action_t'(in_action);
      piece_r <= in_moved_piece;
      sq_r    <= in_to_square;
      sidx_r  <= in_stats_index;
      depth_r <= in_remaining_depth;
    end else if (set_query) begin
      act_r   <= ACT_QUERY;
    end
    sw_waddr_r <= cnt_r[HIST_AW-1:0];
    sh_r       <= sh_nxt;
    hv_r       <= hv_nxt;
    f_r        <= f_nxt;
    a_r        <= a_nxt;
    if (div_done) begin
      out_hv_r  <= HV_W'(hv_r);
      out_pct_r <= div_quot;
    end
  end

  hafh_hist_mem u_hist_mem (
    .clk     (clk),
    .wr      (hist_wr),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd)
  );

  hafh_stat_mem u_stat_mem (
    .clk     (clk),
    .wr      (stat_wr),
    .rd_addr (STATS_AW'(pt_sidx)),
    .rd_fail (stat_rd_fail),
    .rd_att  (stat_rd_att)
  );

  hafh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .fail  (f_r),
    .att   (a_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign busy                  = (state_r != ST_IDLE);
  assign out_valid             = out_valid_r;
  assign out_history_value     = out_hv_r;
  assign out_fail_high_percent = out_pct_r;

  `HAFH_ASSERT(a_out_after_div, out_valid_r |-> $past(div_done), "result without divider done")
  `HAFH_ASSERT(a_out_single, out_valid_r |=> !out_valid_r, "result strobe longer than one cycle")
  `HAFH_ASSERT_IMP(a_hist_wr_range, hist_wr.en, 32'(hist_wr.addr) < HIST_ENTRIES, "history write out of range")
  `HAFH_ASSERT_IMP(a_done_in_wait, div_done, state_r == ST_DWAIT, "divider done outside wait")
endmodule

// ----- hw/rtl/hafh_hist_mem.sv -----
// ---------------------------------------------------------------------------
// History counter memory
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module hafh_hist_mem import hafh_pkg::*; (
  input  logic                    clk,
  input  hist_wr_t                wr,
  input  logic [HIST_AW-1:0]      rd_addr,
  output logic [HISTORY_BITS-1:0] rd_data
);
  logic [HISTORY_BITS-1:0] mem_r [HIST_ENTRIES];
  logic [HISTORY_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

// ----- hw/rtl/hafh_stat_mem.sv -----
// ---------------------------------------------------------------------------
// Fail-high statistics memory
// Fail and attempt counter pairs, one write and one read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module hafh_stat_mem import hafh_pkg::*; (
  input  logic                clk,
  input  stat_wr_t            wr,
  input  logic [STATS_AW-1:0] rd_addr,
  output logic [STAT_W-1:0]   rd_fail,
  output logic [STAT_W-1:0]   rd_att
);
  logic [2*STAT_W-1:0] mem_r [STATS_ENTRIES];
  logic [2*STAT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= {wr.fail, wr.att};
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_fail = rd_data_r[2*STAT_W-1:STAT_W];
  assign rd_att  = rd_data_r[STAT_W-1:0];
endmodule

// ----- hw/rtl/hafh_div.sv -----
// ---------------------------------------------------------------------------
// Fail-high percentage divider
// Restoring division of 100*fails by attempts, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module hafh_div import hafh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [STAT_W-1:0] fail,
  input  logic [STAT_W-1:0] att,
  output logic              done,
  output logic [PCT_W-1:0]  quot
);
  localparam int STEP_W = $clog2(PCT_W + 1);

  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  den_r;
  logic [PCT_W-1:0]  q_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              zero_r;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= STEP_W'(PCT_W);
      end else if (run_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= NUM_W'(fail) * NUM_W'(PCT_SCALE);
      den_r  <= NUM_W'(att) << (PCT_W - 1);
      q_r    <= '0;
      zero_r <= (att == '0);
    end else if (run_r) begin
      if (rem_r >= den_r) begin
        rem_r <= rem_r - den_r;
        q_r   <= {q_r[PCT_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[PCT_W-2:0], 1'b0};
      end
      den_r <= den_r >> 1;
    end
  end

  assign done = done_r;
  assign quot = zero_r ? '0 : q_r;
endmodule
